// File: hdl/efws_pkg.sv
`default_nettype none
package efws_pkg;

  localparam int MAX_WORKERS = 32;
  localparam int CLASS_COUNT = 4;
  localparam int TIME_W      = 32;
  localparam int WIDX_W      = 5;
  localparam int WCNT_W      = 6;
  localparam int CLS_W       = 2;
  localparam int MAP_W       = 64;
  localparam int CFG_IDX_W   = 1;

  typedef logic [TIME_W-1:0] time_t;

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORKER_COUNT = 1'b0,
    CFG_CLASS_MAP    = 1'b1
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_en;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_pop;
    logic n_zero;
    logic scan_last;
  } ctrl_status_t;

  // Unsigned add that saturates at the all-ones value.
  function automatic time_t sat_add(input time_t a, input time_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/efws_in_if.sv
`default_nettype none
interface efws_in_if;
  import efws_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [TIME_W-1:0]      now_time;
  logic [CLASS_COUNT-1:0] allowed_classes;
  logic [TIME_W-1:0]      length_class_zero;
  logic [TIME_W-1:0]      length_class_one;
  logic [TIME_W-1:0]      length_class_two;
  logic [TIME_W-1:0]      length_class_three;
  logic                   high_priority;
  logic [WIDX_W-1:0]      pop_worker;
  logic [TIME_W-1:0]      popped_length;

  modport source (
    output valid, cmd, now_time, allowed_classes, length_class_zero, length_class_one,
           length_class_two, length_class_three, high_priority, pop_worker, popped_length,
    input  ready
  );

  modport sink (
    input  valid, cmd, now_time, allowed_classes, length_class_zero, length_class_one,
           length_class_two, length_class_three, high_priority, pop_worker, popped_length,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/efws_out_if.sv
`default_nettype none
interface efws_out_if;
  import efws_pkg::*;

  logic              valid;
  logic              ready;
  logic [WIDX_W-1:0] chosen_worker;
  logic [TIME_W-1:0] chosen_length;
  logic              priority_out;
  logic              no_capable_worker;

  modport source (
    output valid, chosen_worker, chosen_length, priority_out, no_capable_worker,
    input  ready
  );

  modport sink (
    input  valid, chosen_worker, chosen_length, priority_out, no_capable_worker,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/earliest_finish_worker_select_unit.sv
`default_nettype none
// Earliest-finish worker selection unit.
// Items arrive on in_ch and results leave on out_ch, each a valid/ready
// channel; a transfer happens on a rising edge with valid and ready high.
// A push scans the participating workers one per cycle: it raises each
// ready time to the current time and picks the capable worker with the
// least ready time plus queued work plus class length. A pop updates the
// named worker. Every item gives exactly one result.
// Order: a push scans the N participating workers, where N is the
// effective worker count (0 to 32), through a two-stage compare pipeline,
// flushes that pipeline and then loads its result; a pop loads its result
// directly. Once the result is registered the unit is idle again and
// can take the next item.
// The result sits in an output register; while the receiver stalls the
// unit goes on to accept and process the next item, and only waits at the
// end of that item until the register is free. Reset (rst_n low at a clock
// edge) clears all worker times and queued work, both configuration
// registers and the channel state. Configuration is written through cfg_we,
// cfg_index and cfg_wdata by the user only while idle; no check enforces it.
module earliest_finish_worker_select_unit
  import efws_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  efws_in_if.sink                   in_ch,
  efws_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MAP_W-1:0]     cfg_wdata
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // The controller sequences accept, scan, pipeline flush and result load.
  efws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the worker state, the captured item and the result.
  efws_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_cmd                (in_ch.cmd),
    .in_now_time           (in_ch.now_time),
    .in_allowed_classes    (in_ch.allowed_classes),
    .in_length_class_zero  (in_ch.length_class_zero),
    .in_length_class_one   (in_ch.length_class_one),
    .in_length_class_two   (in_ch.length_class_two),
    .in_length_class_three (in_ch.length_class_three),
    .in_high_priority      (in_ch.high_priority),
    .in_pop_worker         (in_ch.pop_worker),
    .in_popped_length      (in_ch.popped_length),
    .out_chosen_worker     (out_ch.chosen_worker),
    .out_chosen_length     (out_ch.chosen_length),
    .out_priority_out      (out_ch.priority_out),
    .out_no_capable_worker (out_ch.no_capable_worker)
  );

  // While an input transfer is possible no scan or result load is running.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!cmd.scan_en && !cmd.finish))
    else $error("scan or result load while accepting input");

  // A result is only loaded when the output register is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwrote an untaken result");

  // A loaded result is offered in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_ch.valid)
    else $error("loaded result not offered");

  // The unit returns to accepting input right after loading a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> in_ch.ready)
    else $error("unit not ready after finishing an item");

endmodule
`default_nettype wire

// File: hdl/efws_ctrl.sv
`default_nettype none
module efws_ctrl
  import efws_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire ctrl_status_t status,
  output ctrl_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    cmd.load    = in_valid && (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          if (status.in_pop) begin
            state_nxt = ST_FINISH;
          end else if (status.n_zero) begin
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/efws_datapath.sv
`default_nettype none
module efws_datapath
  import efws_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire ctrl_cmd_t              cmd,
  output ctrl_status_t                status,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [MAP_W-1:0]       cfg_wdata,
  input  wire logic                   in_cmd,
  input  wire logic [TIME_W-1:0]      in_now_time,
  input  wire logic [CLASS_COUNT-1:0] in_allowed_classes,
  input  wire logic [TIME_W-1:0]      in_length_class_zero,
  input  wire logic [TIME_W-1:0]      in_length_class_one,
  input  wire logic [TIME_W-1:0]      in_length_class_two,
  input  wire logic [TIME_W-1:0]      in_length_class_three,
  input  wire logic                   in_high_priority,
  input  wire logic [WIDX_W-1:0]      in_pop_worker,
  input  wire logic [TIME_W-1:0]      in_popped_length,
  output logic [WIDX_W-1:0]           out_chosen_worker,
  output logic [TIME_W-1:0]           out_chosen_length,
  output logic                        out_priority_out,
  output logic                        out_no_capable_worker
);

  // Configuration.
  logic [WCNT_W-1:0] worker_count_r;
  logic [MAP_W-1:0]  class_map_r;
  logic [WCNT_W-1:0] n_eff;

  // Captured item.
  logic                   cmd_r;
  time_t                  now_r;
  logic [CLASS_COUNT-1:0] allowed_r;
  time_t                  len_r [CLASS_COUNT];
  logic                   prio_r;
  logic [WIDX_W-1:0]      pw_r;
  time_t                  plen_r;

  // Worker state.
  time_t ready_time_r  [MAX_WORKERS];
  time_t queued_work_r [MAX_WORKERS];

  // Scan pipeline.
  logic [WIDX_W-1:0] idx_r;
  logic              a_valid_r;
  logic              a_cap_r;
  logic [WIDX_W-1:0] a_idx_r;
  time_t             a_sum_r;
  time_t             a_len_r;
  logic              found_r;
  logic [WIDX_W-1:0] best_idx_r;
  time_t             best_cost_r;
  time_t             best_len_r;

  // Result register.
  logic [WIDX_W-1:0] res_worker_r;
  time_t             res_length_r;
  logic              res_prio_r;
  logic              res_none_r;

  logic [CLS_W-1:0]  cls;
  time_t             rt_up;
  time_t             cost;
  logic              better;
  logic              pop_ok;
  time_t             qw_pop;

  assign n_eff = (worker_count_r > WCNT_W'(MAX_WORKERS)) ? WCNT_W'(MAX_WORKERS)
                                                         : worker_count_r;

  assign status.in_pop    = (in_cmd == CMD_POP);
  assign status.n_zero    = (n_eff == '0);
  assign status.scan_last = (({1'b0, idx_r} + WCNT_W'(1)) == n_eff);

  assign cls    = class_map_r[{idx_r, 1'b0} +: CLS_W];
  assign rt_up  = (ready_time_r[idx_r] < now_r) ? now_r : ready_time_r[idx_r];
  assign cost   = sat_add(a_sum_r, a_len_r);
  assign better = a_valid_r && a_cap_r && (!found_r || (cost < best_cost_r));
  assign pop_ok = ({1'b0, pw_r} < n_eff);
  assign qw_pop = (queued_work_r[pw_r] > plen_r) ? (queued_work_r[pw_r] - plen_r) : '0;

  assign out_chosen_worker     = res_worker_r;
  assign out_chosen_length     = res_length_r;
  assign out_priority_out      = res_prio_r;
  assign out_no_capable_worker = res_none_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_count_r <= '0;
      class_map_r    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WORKER_COUNT) begin
        worker_count_r <= cfg_wdata[WCNT_W-1:0];
      end else begin
        class_map_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_cmd;
      now_r     <= in_now_time;
      allowed_r <= in_allowed_classes;
      len_r[0]  <= in_length_class_zero;
      len_r[1]  <= in_length_class_one;
      len_r[2]  <= in_length_class_two;
      len_r[3]  <= in_length_class_three;
      prio_r    <= in_high_priority;
      pw_r      <= in_pop_worker;
      plen_r    <= in_popped_length;
    end
  end

  // Stage A reads the worker under the scan index and raises its ready time;
  // stage B adds the class length and keeps the running minimum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      a_valid_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      a_valid_r <= cmd.scan_en;
      if (cmd.load) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.scan_en) begin
          idx_r <= idx_r + WIDX_W'(1);
        end
        if (better) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      a_sum_r <= sat_add(rt_up, queued_work_r[idx_r]);
      a_len_r <= len_r[cls];
      a_cap_r <= allowed_r[cls];
      a_idx_r <= idx_r;
    end
    if (better) begin
      best_idx_r  <= a_idx_r;
      best_cost_r <= cost;
      best_len_r  <= a_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_WORKERS; i++) begin
        ready_time_r[i]  <= '0;
        queued_work_r[i] <= '0;
      end
    end else begin
      if (cmd.scan_en) begin
        ready_time_r[idx_r] <= rt_up;
      end
      if (cmd.finish) begin
        if (cmd_r == CMD_PUSH) begin
          if (found_r) begin
            queued_work_r[best_idx_r] <= sat_add(queued_work_r[best_idx_r], best_len_r);
          end
        end else if (pop_ok) begin
          queued_work_r[pw_r] <= qw_pop;
          ready_time_r[pw_r]  <= sat_add(now_r, plen_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (cmd_r == CMD_PUSH) begin
        res_worker_r <= found_r ? best_idx_r : '0;
        res_length_r <= found_r ? best_len_r : '0;
        res_prio_r   <= prio_r;
        res_none_r   <= !found_r;
      end else begin
        res_worker_r <= pw_r;
        res_length_r <= plen_r;
        res_prio_r   <= 1'b0;
        res_none_r   <= !pop_ok;
      end
    end
  end

endmodule
`default_nettype wire
